// ===== hw/rtl/sirs_pkg.sv =====
package sirs_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BASE_SIZE = 3'd0;
  localparam logic [2:0] CFG_ALPHA_0   = 3'd1;
  localparam logic [2:0] CFG_ALPHA_1   = 3'd2;
  localparam logic [2:0] CFG_ALPHA_2   = 3'd3;
  localparam logic [2:0] CFG_ALPHA_3   = 3'd4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned BASE_W      = 6;
  localparam int unsigned DIGIT_W     = 5;
  localparam int unsigned CHAR_W      = 8;

  localparam logic [BASE_W-1:0] RADIX_MAX = 6'd32;
  localparam logic [BASE_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RD   = 5'b00100,
    S_LD   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/signed_int_to_radix_string.sv =====
// Sequence: take the word, run the shared bit-serial divider once per digit, then hand
// out a minus sign first if the word is negative, then each digit character (RAM read,
// load, hand-off), each character waiting as long as out_ready is low.
// Throughput: one word at a time; in_ready is high only when no conversion is pending.
// Zero and a bad radix give a single character in the cycle right after acceptance.
// Reset (synchronous, rst_n low) clears the sequencer and the configuration registers.
module signed_int_to_radix_string #(
  parameter int unsigned MAX_DIGITS  = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [VALUE_WIDTH-1:0]        in_value,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sirs_pkg::CHAR_W-1:0]          out_char,
  output logic                                 out_is_last,
  output logic                                 out_bad_base,

  input  logic                                 cfg_we,
  input  logic [sirs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BIT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  // Configuration registers.
  logic [sirs_pkg::BASE_W-1:0]     base_size_r;
  logic [sirs_pkg::CFG_DATA_W-1:0] alpha0_r, alpha1_r, alpha2_r, alpha3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r <= '0;
      alpha0_r    <= '0;
      alpha1_r    <= '0;
      alpha2_r    <= '0;
      alpha3_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sirs_pkg::CFG_BASE_SIZE: base_size_r <= cfg_wdata[sirs_pkg::BASE_W-1:0];
        sirs_pkg::CFG_ALPHA_0:   alpha0_r    <= cfg_wdata;
        sirs_pkg::CFG_ALPHA_1:   alpha1_r    <= cfg_wdata;
        sirs_pkg::CFG_ALPHA_2:   alpha2_r    <= cfg_wdata;
        sirs_pkg::CFG_ALPHA_3:   alpha3_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [4*sirs_pkg::CFG_DATA_W-1:0] alpha_vec;
  logic [sirs_pkg::BASE_W-1:0]       radix;

  assign alpha_vec = {alpha3_r, alpha2_r, alpha1_r, alpha0_r};
  assign radix     = (base_size_r > sirs_pkg::RADIX_MAX) ? sirs_pkg::RADIX_MAX : base_size_r;

  // Sequencer and divider state.
  sirs_pkg::state_t             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]       quot_r, quot_nxt;
  logic [sirs_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [BIT_W-1:0]             bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         neg_r, neg_nxt;
  logic [sirs_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                         last_r, last_nxt;
  logic                         bad_r, bad_nxt;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [sirs_pkg::DIGIT_W-1:0] ram_rdata;

  logic                         in_neg;
  logic [VALUE_WIDTH-1:0]       in_mag;
  logic [sirs_pkg::BASE_W-1:0]  trial;
  logic                         qbit;
  logic [VALUE_WIDTH-1:0]       quot_step;
  logic [sirs_pkg::DIGIT_W-1:0] rem_step;
  logic [CNT_W-1:0]             cnt_inc;

  assign in_neg = in_value[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;

  // One restoring step: shift the next dividend bit into the partial remainder.
  assign trial     = {rem_r, quot_r[VALUE_WIDTH-1]};
  assign qbit      = (trial >= radix);
  assign rem_step  = qbit ? sirs_pkg::DIGIT_W'(trial - radix) : trial[sirs_pkg::DIGIT_W-1:0];
  assign quot_step = {quot_r[VALUE_WIDTH-2:0], qbit};
  assign cnt_inc   = cnt_r + CNT_W'(1);

  assign ram_waddr = cnt_r[AW-1:0];
  assign ram_raddr = AW'(cnt_r - CNT_W'(1));

  always_comb begin
    state_nxt   = state_r;
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    bit_cnt_nxt = bit_cnt_r;
    cnt_nxt     = cnt_r;
    neg_nxt     = neg_r;
    char_nxt    = char_r;
    last_nxt    = last_r;
    bad_nxt     = bad_r;
    ram_we      = 1'b0;

    unique case (state_r)
      sirs_pkg::S_IDLE: begin
        if (in_valid) begin
          quot_nxt    = in_mag;
          rem_nxt     = '0;
          bit_cnt_nxt = BIT_W'(VALUE_WIDTH - 1);
          cnt_nxt     = '0;
          neg_nxt     = in_neg;
          if (in_value == '0) begin
            char_nxt  = alpha0_r[sirs_pkg::CHAR_W-1:0];
            last_nxt  = 1'b1;
            bad_nxt   = 1'b0;
            state_nxt = sirs_pkg::S_OUT;
          end else if (radix < sirs_pkg::RADIX_MIN) begin
            char_nxt  = '0;
            last_nxt  = 1'b1;
            bad_nxt   = 1'b1;
            state_nxt = sirs_pkg::S_OUT;
          end else begin
            state_nxt = sirs_pkg::S_DIV;
          end
        end
      end

      sirs_pkg::S_DIV: begin
        quot_nxt    = quot_step;
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r - BIT_W'(1);
        if (bit_cnt_r == '0) begin
          // Digit done: store the remainder and start on the quotient.
          ram_we      = 1'b1;
          cnt_nxt     = cnt_inc;
          rem_nxt     = '0;
          bit_cnt_nxt = BIT_W'(VALUE_WIDTH - 1);
          if (quot_step == '0 || cnt_inc == CNT_W'(MAX_DIGITS)) begin
            if (neg_r) begin
              char_nxt  = sirs_pkg::MINUS_CHAR;
              last_nxt  = 1'b0;
              bad_nxt   = 1'b0;
              state_nxt = sirs_pkg::S_OUT;
            end else begin
              state_nxt = sirs_pkg::S_RD;
            end
          end
        end
      end

      sirs_pkg::S_RD: begin
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = sirs_pkg::S_LD;
      end

      sirs_pkg::S_LD: begin
        char_nxt  = alpha_vec[{ram_rdata, 3'b000} +: sirs_pkg::CHAR_W];
        last_nxt  = (cnt_r == '0);
        bad_nxt   = 1'b0;
        state_nxt = sirs_pkg::S_OUT;
      end

      sirs_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = last_r ? sirs_pkg::S_IDLE : sirs_pkg::S_RD;
        end
      end

      default: state_nxt = sirs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sirs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
    bad_r     <= bad_nxt;
  end

  sirs_ram #(
    .WIDTH (sirs_pkg::DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rem_step),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready     = (state_r == sirs_pkg::S_IDLE);
  assign out_valid    = (state_r == sirs_pkg::S_OUT);
  assign out_char     = char_r;
  assign out_is_last  = last_r;
  assign out_bad_base = bad_r;

endmodule

// ===== hw/rtl/sirs_ram.sv =====
module sirs_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
